@@ rtl/amc_pkg.sv @@
// Shared types and constants for the ambiguity median cost block.
// Depends on nothing; every rtl file imports it.
`timescale 1ns / 1ps

package amc_pkg;

	localparam int SET_BITS        = 8;
	localparam int OUT_COST_W      = 17;
	localparam int DEF_MAX_SYMBOLS = 8;
	localparam int DEF_COST_BITS   = 16;

	localparam logic [OUT_COST_W-1:0] OUT_COST_MAX = '1;
	localparam logic [3:0]            ALPH_RESET   = 4'd5;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [2:0]  row_symbol;
		logic [2:0]  col_symbol;
		logic [15:0] entry_cost;
		logic [7:0]  first_set;
		logic [7:0]  second_set;
	} in_item_t;

	typedef struct packed {
		logic [OUT_COST_W-1:0] min_cost;
		logic [7:0]            median_set;
		logic                  empty_set_error;
	} out_item_t;

	// one cost table write, top level to table
	typedef struct packed {
		logic        en;
		logic [2:0]  row;
		logic [2:0]  col;
		logic [15:0] cost;
	} tbl_wr_t;

endpackage

@@ rtl/amc_table.sv @@
// Symbol-to-symbol cost table held in flip-flops, one write port.
// Depends on amc_pkg; every entry is presented in parallel to the query pipeline.
`timescale 1ns / 1ps

module amc_table #(
	parameter int MAX_SYMBOLS = amc_pkg::DEF_MAX_SYMBOLS,
	parameter int COST_BITS   = amc_pkg::DEF_COST_BITS,
	localparam int SYM_N      = (MAX_SYMBOLS < amc_pkg::SET_BITS) ?
	                            MAX_SYMBOLS : amc_pkg::SET_BITS
) (
	input  logic                                      clk,
	input  amc_pkg::tbl_wr_t                          wr,
	output logic [SYM_N-1:0][SYM_N-1:0][COST_BITS-1:0] cost
);
	import amc_pkg::*;

	localparam int EXT_W = (COST_BITS > 16) ? COST_BITS : 16;

	logic [SYM_N-1:0][SYM_N-1:0][COST_BITS-1:0] cost_q;
	logic [EXT_W-1:0]                           wr_ext;

	assign wr_ext = EXT_W'(wr.cost);

	// rows or columns beyond the table never match and the write drops
	always_ff @(posedge clk) begin
		for (int r = 0; r < SYM_N; r++) begin
			for (int c = 0; c < SYM_N; c++) begin
				if (wr.en && wr.row == 3'(r) && wr.col == 3'(c)) begin
					cost_q[r][c] <= wr_ext[COST_BITS-1:0];
				end
			end
		end
	end

	assign cost = cost_q;

endmodule

@@ rtl/ambiguity_median_cost_top.sv @@
// Top level of the ambiguity median cost block: config register and query pipeline.
// Depends on amc_pkg and amc_table.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+--------------------------
//   in      | input     | in_valid / in_ready | in_data   (in_item_t)
//   out     | output    | out_valid/out_ready | out_data  (out_item_t)
//   cfg     | input     | cfg_we              | cfg_wdata (alphabet size)
//
// One beat per cycle while the out channel does not stall; a query's result passes through
// five register stages: capture, nearest cost per row, sum, row minimum, median.
// Table writes complete at the accepting edge and produce no result.
// Each stage loads when empty or when the stage after it moves, so bubbles
// collapse and a full stalled pipe holds in_ready low.
// Reset clears valid bits and sets the alphabet size to five; table undefined until written.
`timescale 1ns / 1ps

module ambiguity_median_cost_top #(
	parameter int MAX_SYMBOLS = amc_pkg::DEF_MAX_SYMBOLS,
	parameter int COST_BITS   = amc_pkg::DEF_COST_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  amc_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output amc_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_wdata
);
	import amc_pkg::*;

	localparam int SYM_N = (MAX_SYMBOLS < SET_BITS) ? MAX_SYMBOLS : SET_BITS;
	localparam int SUM_W = (COST_BITS + 1 > OUT_COST_W) ? COST_BITS + 1 : OUT_COST_W;

	logic [3:0] alph_q;
	logic [3:0] alph_eff;
	logic [SET_BITS-1:0] live;

	tbl_wr_t tbl_wr;
	logic [SYM_N-1:0][SYM_N-1:0][COST_BITS-1:0] cost;

	logic acc, q_acc;
	logic en1, en2, en3, en4, en_o;

	logic                v1, v2, v3, v4, out_valid_q;
	logic [SET_BITS-1:0] first_s1, second_s1, live_s1, live_s2, live_s3, live_s4;
	logic                err_s1, err_s2, err_s3, err_s4;
	logic [COST_BITS-1:0] near1_s2 [SYM_N];
	logic [COST_BITS-1:0] near2_s2 [SYM_N];
	logic [COST_BITS-1:0] near1_d  [SYM_N];
	logic [COST_BITS-1:0] near2_d  [SYM_N];
	logic [OUT_COST_W-1:0] sum_d  [SYM_N];
	logic [OUT_COST_W-1:0] sum_s3 [SYM_N];
	logic [OUT_COST_W-1:0] sum_s4 [SYM_N];
	logic [OUT_COST_W-1:0] min_d, min_s4;
	logic [SET_BITS-1:0]   median_d;
	out_item_t             out_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alph_q <= ALPH_RESET;
		end else if (cfg_we) begin
			alph_q <= cfg_wdata;
		end
	end

	assign alph_eff = (alph_q > 4'(SYM_N)) ? 4'(SYM_N) : alph_q;

	always_comb begin
		for (int i = 0; i < SET_BITS; i++) begin
			live[i] = (4'(i) < alph_eff);
		end
	end

	// handshake and stage enables
	assign en_o     = !out_valid_q || out_ready;
	assign en4      = !v4 || en_o;
	assign en3      = !v3 || en4;
	assign en2      = !v2 || en3;
	assign en1      = !v1 || en2;
	assign in_ready = en1;
	assign acc      = in_valid && in_ready;
	assign q_acc    = acc && (in_data.cmd == CMD_QUERY);

	assign tbl_wr.en   = acc && (in_data.cmd == CMD_WRITE);
	assign tbl_wr.row  = in_data.row_symbol;
	assign tbl_wr.col  = in_data.col_symbol;
	assign tbl_wr.cost = in_data.entry_cost;

	amc_table #(
		.MAX_SYMBOLS (MAX_SYMBOLS),
		.COST_BITS   (COST_BITS)
	) u_table (
		.clk  (clk),
		.wr   (tbl_wr),
		.cost (cost)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1          <= 1'b0;
			v2          <= 1'b0;
			v3          <= 1'b0;
			v4          <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1)  v1          <= q_acc;
			if (en2)  v2          <= v1;
			if (en3)  v3          <= v2;
			if (en4)  v4          <= v3;
			if (en_o) out_valid_q <= v4;
		end
	end

	// stage 1: capture the sets, trimmed to the alphabet
	always_ff @(posedge clk) begin
		if (en1) begin
			first_s1  <= in_data.first_set & live;
			second_s1 <= in_data.second_set & live;
			live_s1   <= live;
			err_s1    <= ((in_data.first_set & live) == '0) ||
			             ((in_data.second_set & live) == '0);
		end
	end

	// stage 2: cheapest cost from each row into each set
	always_comb begin
		for (int s = 0; s < SYM_N; s++) begin
			near1_d[s] = '1;
			near2_d[s] = '1;
			for (int t = 0; t < SYM_N; t++) begin
				if (first_s1[t] && cost[s][t] < near1_d[s]) near1_d[s] = cost[s][t];
				if (second_s1[t] && cost[s][t] < near2_d[s]) near2_d[s] = cost[s][t];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			near1_s2 <= near1_d;
			near2_s2 <= near2_d;
			live_s2  <= live_s1;
			err_s2   <= err_s1;
		end
	end

	// stage 3: per-row sum, saturated to the output width
	always_comb begin
		logic [SUM_W-1:0] wide;
		wide = '0;
		for (int s = 0; s < SYM_N; s++) begin
			wide = SUM_W'(near1_s2[s]) + SUM_W'(near2_s2[s]);
			sum_d[s] = (wide > SUM_W'(OUT_COST_MAX)) ? OUT_COST_MAX : wide[OUT_COST_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			sum_s3  <= sum_d;
			live_s3 <= live_s2;
			err_s3  <= err_s2;
		end
	end

	// stage 4: least sum over rows in the alphabet
	always_comb begin
		min_d = OUT_COST_MAX;
		for (int s = 0; s < SYM_N; s++) begin
			if (live_s3[s] && sum_s3[s] < min_d) min_d = sum_s3[s];
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			sum_s4  <= sum_s3;
			min_s4  <= min_d;
			live_s4 <= live_s3;
			err_s4  <= err_s3;
		end
	end

	// output stage: median mask, error override
	always_comb begin
		median_d = '0;
		for (int s = 0; s < SYM_N; s++) begin
			median_d[s] = live_s4[s] && (sum_s4[s] == min_s4);
		end
	end

	always_ff @(posedge clk) begin
		if (en_o) begin
			out_q.min_cost        <= err_s4 ? OUT_COST_MAX : min_s4;
			out_q.median_set      <= err_s4 ? '0 : median_d;
			out_q.empty_set_error <= err_s4;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.empty_set_error |->
			out_data.min_cost == OUT_COST_MAX && out_data.median_set == '0)
		else $error("error beat with nonempty median or cost");

	a_median_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.empty_set_error |-> out_data.median_set != '0)
		else $error("good beat with empty median");

	a_median_live: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.median_set & ~live) == '0)
		else $error("median outside alphabet");

	a_query_enters: assert property (@(posedge clk) disable iff (!arst_n)
		q_acc |=> v1)
		else $error("accepted query lost at stage 1");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v1 |-> in_ready)
		else $error("input stalled with empty first stage");
`endif

endmodule

@@ sim/amc_checker.sv @@
// Checker for the ambiguity median cost block: shadows the cost table and the
// alphabet size, predicts every query result and compares it on the out channel.
// Depends on amc_pkg; instantiated beside the block by tb.
`timescale 1ns / 1ps

module amc_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  amc_pkg::in_item_t  in_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  amc_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_wdata,
	output int                 mismatches,
	output int                 pending,
	output int                 results_seen,
	output int                 error_results
);
	import amc_pkg::*;

	logic [15:0] cost_shadow [0:63];
	logic [3:0]  alph_shadow;
	out_item_t   medians_due [$];
	out_item_t   due_item;

	function automatic out_item_t predict_median(input in_item_t query);
		out_item_t  res;
		int         span;
		logic [8:0] live;
		logic [7:0] fset;
		logic [7:0] sset;
		logic [15:0] near_f;
		logic [15:0] near_s;
		logic [16:0] sum;
		logic [16:0] best;
		logic       any;
		span = (alph_shadow > 4'd8) ? 8 : int'(alph_shadow);
		live = (9'd1 << span) - 9'd1;
		fset = query.first_set & live[7:0];
		sset = query.second_set & live[7:0];
		res.min_cost = OUT_COST_MAX;
		res.median_set = 8'h00;
		res.empty_set_error = 1'b1;
		if (fset == 8'h00 || sset == 8'h00)
			return res;
		best = '0;
		any = 1'b0;
		for (int s = 0; s < span; s++) begin
			near_f = 16'hFFFF;
			near_s = 16'hFFFF;
			for (int t = 0; t < span; t++) begin
				if (fset[t] && cost_shadow[s*8+t] < near_f)
					near_f = cost_shadow[s*8+t];
				if (sset[t] && cost_shadow[s*8+t] < near_s)
					near_s = cost_shadow[s*8+t];
			end
			sum = {1'b0, near_f} + {1'b0, near_s};
			if (!any || sum < best) begin
				best = sum;
				res.median_set = 8'h00;
				res.median_set[s] = 1'b1;
				any = 1'b1;
			end else if (sum == best) begin
				res.median_set[s] = 1'b1;
			end
		end
		res.min_cost = best;
		res.empty_set_error = 1'b0;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			medians_due.delete();
			alph_shadow = ALPH_RESET;
			for (int i = 0; i < 64; i++)
				cost_shadow[i] = 16'h0000;
			mismatches = 0;
			pending = 0;
			results_seen = 0;
			error_results = 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (out_data.empty_set_error)
					error_results++;
				if (medians_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result beat with nothing due: cost %h median %h err %b",
							$realtime, out_data.min_cost, out_data.median_set,
							out_data.empty_set_error);
				end else begin
					due_item = medians_due.pop_front();
					if (out_data.min_cost !== due_item.min_cost
							|| out_data.median_set !== due_item.median_set
							|| out_data.empty_set_error !== due_item.empty_set_error) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: median mismatch: want cost %h median %h err %b, got cost %h median %h err %b",
								$realtime, due_item.min_cost, due_item.median_set,
								due_item.empty_set_error, out_data.min_cost,
								out_data.median_set, out_data.empty_set_error);
					end
				end
			end
			if (in_valid && in_ready) begin
				if (in_data.cmd == CMD_WRITE)
					cost_shadow[{in_data.row_symbol, in_data.col_symbol}] = in_data.entry_cost;
				else
					medians_due.push_back(predict_median(in_data));
			end
			if (cfg_we)
				alph_shadow = cfg_wdata;
			pending = medians_due.size();
		end
	end

endmodule

@@ sim/tb.sv @@
// Testbench top for ambiguity_median_cost_top: clock, reset, stimulus and verdict.
// Depends on amc_pkg, the block's rtl and amc_checker, which predicts and compares.
`timescale 1ns / 1ps

module tb;
	import amc_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 6;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 1200;
	localparam int SEGMENT_ITEMS = 100;
	localparam int LONG_HOLD     = 300;
	localparam int SETTLE_CYCLES = 12;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	in_item_t   in_data   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_item_t  out_data;
	logic       cfg_we    = 1'b0;
	logic [3:0] cfg_wdata = 4'd0;

	int   mismatches;
	int   pending;
	int   results_seen;
	int   error_results;
	int   snd_idle_pct = 0;
	int   rcv_idle_pct = 0;
	int   hold_left    = 0;
	logic hold_req     = 1'b0;
	int   cycle_count  = 0;
	int   writes_sent  = 0;
	int   queries_sent = 0;

	logic [3:0] alph_plan [0:11] = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd3, 4'd9,
		4'd6, 4'd2, 4'd4, 4'd7, 4'd12, 4'd5};

	ambiguity_median_cost_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	amc_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.mismatches    (mismatches),
		.pending       (pending),
		.results_seen  (results_seen),
		.error_results (error_results)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// receiver: random back-pressure, or a long hold when asked
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = LONG_HOLD;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= (int'($urandom_range(99)) >= rcv_idle_pct);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
		$display("tb failed");
		$finish;
	end

	function automatic in_item_t random_item();
		in_item_t it;
		it.cmd = 1'($urandom);
		it.row_symbol = 3'($urandom);
		it.col_symbol = 3'($urandom);
		it.entry_cost = 16'($urandom);
		it.first_set = 8'($urandom);
		it.second_set = 8'($urandom);
		return it;
	endfunction

	function automatic logic [15:0] pick_cost();
		int roll;
		roll = $urandom_range(99);
		if (roll < 10)
			return 16'h0000;
		if (roll < 20)
			return 16'hFFFF;
		if (roll < 50)
			return 16'($urandom_range(3));
		return 16'($urandom);
	endfunction

	function automatic logic [7:0] pick_set();
		int roll;
		roll = $urandom_range(99);
		if (roll < 8)
			return 8'h00;
		if (roll < 18)
			return 8'hFF;
		if (roll < 38)
			return 8'(1 << $urandom_range(7));
		if (roll < 48)
			return 8'($urandom) & 8'hF0;
		return 8'($urandom);
	endfunction

	// offer one beat after a random gap, hold it until accepted
	task automatic send_beat(input in_item_t item);
		@(negedge clk);
		while (int'($urandom_range(99)) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do
			@(posedge clk);
		while (!in_ready);
		if (item.cmd == CMD_WRITE)
			writes_sent++;
		else
			queries_sent++;
	endtask

	task automatic write_entry(input logic [2:0] row, input logic [2:0] col,
			input logic [15:0] cost);
		in_item_t it;
		it = random_item();
		it.cmd = CMD_WRITE;
		it.row_symbol = row;
		it.col_symbol = col;
		it.entry_cost = cost;
		send_beat(it);
	endtask

	task automatic query(input logic [7:0] first, input logic [7:0] second);
		in_item_t it;
		it = random_item();
		it.cmd = CMD_QUERY;
		it.first_set = first;
		it.second_set = second;
		send_beat(it);
	endtask

	// drop valid, wait for every due result, then let the pipe settle
	task automatic drain_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic set_alphabet(input logic [3:0] size);
		drain_block();
		cfg_we <= 1'b1;
		cfg_wdata <= size;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int seg;
		repeat (RESET_CYCLES)
			@(negedge clk);
		arst_n <= 1'b1;

		// load the whole table first: free diagonal, a few saturated entries
		for (int r = 0; r < 8; r++)
			for (int c = 0; c < 8; c++)
				write_entry(3'(r), 3'(c), (r == c) ? 16'h0000 :
					((r + c) % 5 == 0) ? 16'hFFFF : 16'($urandom_range(40, 1)));

		// directed beats at the reset alphabet of five
		query(8'hFF, 8'hFF);
		query(8'h00, 8'hFF);
		query(8'hFF, 8'h00);
		query(8'h00, 8'h00);
		query(8'hE0, 8'h1F);
		query(8'h1F, 8'hE0);
		query(8'h01, 8'h01);
		query(8'h01, 8'h10);
		query(8'h10, 8'h10);
		write_entry(3'd0, 3'd4, 16'hFFFF);
		write_entry(3'd4, 3'd0, 16'h0000);
		query(8'h01, 8'h10);
		write_entry(3'd2, 3'd3, 16'h0000);
		query(8'h04, 8'h08);
		write_entry(3'd1, 3'd2, 16'h0007);
		write_entry(3'd2, 3'd1, 16'h0007);
		query(8'h02, 8'h04);
		query(8'h15, 8'h0A);
		query(8'hFF, 8'h80);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % SEGMENT_ITEMS == 0) begin
				seg = i / SEGMENT_ITEMS;
				if (seg < 4) begin
					snd_idle_pct = 15;
					rcv_idle_pct = 51;
				end else if (seg < 8) begin
					snd_idle_pct = 51;
					rcv_idle_pct = 15;
				end else begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
				set_alphabet(alph_plan[seg]);
			end
			// stall the receiver mid-segment while beats keep coming
			if (i == 220 || i == 720 || i == 1020)
				hold_req = 1'b1;
			if ($urandom_range(99) < 22)
				write_entry(3'($urandom), 3'($urandom), pick_cost());
			else
				query(pick_set(), pick_set());
		end

		drain_block();
		$display("sent %0d table writes and %0d queries across twelve alphabet sizes from 0 to 15",
			writes_sent, queries_sent);
		$display("checked %0d results, %0d empty-set errors among them, %0d mismatches",
			results_seen, error_results, mismatches);
		if (mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

@@ ambiguity_median_cost_top.f @@
rtl/amc_pkg.sv
rtl/amc_table.sv
rtl/ambiguity_median_cost_top.sv
sim/amc_checker.sv
sim/tb.sv
